// ----- design/mssp_pkg.sv -----
package mssp_pkg;

  localparam int MaxNodesDef = 64;
  localparam int MaxEdgesDef = 1024;
  localparam int SourcesDef  = 10;

  localparam int NodeW   = 6;
  localparam int WeightW = 16;
  localparam int DistW   = 22;
  localparam int CountW  = 7;
  localparam int StatusW = 2;

  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};

  localparam logic [1:0] OpAdd     = 2'd0;
  localparam logic [1:0] OpCompute = 2'd1;
  localparam logic [1:0] OpQuery   = 2'd2;
  localparam logic [1:0] OpClear   = 2'd3;

  localparam logic [StatusW-1:0] StFound   = 2'd0;
  localparam logic [StatusW-1:0] StUnreach = 2'd1;
  localparam logic [StatusW-1:0] StNoSrc   = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic add_edge;
    logic clear_edges;
    logic start_compute;
    logic init_row;
    logic scan_step;
    logic pick_min;
    logic relax_step;
    logic next_source;
    logic query;
  } mssp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic init_done;
    logic scan_done;
    logic none_found;
    logic relax_done;
    logic sources_done;
    logic res_busy;
  } mssp_sts_t;

endpackage

// ----- design/mssp_ctrl.sv -----
module mssp_ctrl import mssp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic [1:0] in_opcode_i,
  output logic      in_ready_o,
  input  logic      res_busy_i,
  input  mssp_sts_t sts_i,
  output mssp_cmd_t cmd_o
);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SInit  = 3'd1;
  localparam logic [2:0] SScan  = 3'd2;
  localparam logic [2:0] SPick  = 3'd3;
  localparam logic [2:0] SRelax = 3'd4;
  localparam logic [2:0] SNext  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       acc;

  assign in_ready_o = (state_q == SIdle) && !res_busy_i;
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      SIdle: begin
        if (acc) begin
          case (in_opcode_i)
            OpAdd:     cmd_o.add_edge = 1'b1;
            OpClear:   cmd_o.clear_edges = 1'b1;
            OpQuery:   cmd_o.query = 1'b1;
            OpCompute: begin
              cmd_o.start_compute = 1'b1;
              state_d = SInit;
            end
            default: ;
          endcase
        end
      end
      SInit: begin
        cmd_o.init_row = 1'b1;
        if (sts_i.init_done) state_d = SScan;
      end
      SScan: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) state_d = SPick;
      end
      SPick: begin
        cmd_o.pick_min = 1'b1;
        state_d = sts_i.none_found ? SNext : SRelax;
      end
      SRelax: begin
        cmd_o.relax_step = 1'b1;
        if (sts_i.relax_done) state_d = SScan;
      end
      SNext: begin
        cmd_o.next_source = 1'b1;
        state_d = sts_i.sources_done ? SIdle : SInit;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != SIdle) |-> !in_ready_o)
    else $error("ready while computing");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.add_edge, cmd_o.clear_edges, cmd_o.query, cmd_o.start_compute}))
    else $error("more than one item command");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SPick) |=> (state_q == SNext || state_q == SRelax))
    else $error("bad pick successor");

endmodule

// ----- design/mssp_dp.sv -----
module mssp_dp import mssp_pkg::*; #(
  parameter int MAX_NODES = MaxNodesDef,
  parameter int MAX_EDGES = MaxEdgesDef,
  parameter int SOURCES   = SourcesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mssp_cmd_t          cmd_i,
  output mssp_sts_t          sts_o,
  input  logic [CountW-1:0]  node_count_i,
  input  logic [NodeW-1:0]   node_a_i,
  input  logic [NodeW-1:0]   node_b_i,
  input  logic [WeightW-1:0] weight_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output logic [DistW-1:0]   res_distance_o,
  output logic [StatusW-1:0] res_status_o
);

  localparam int NW  = $clog2(MAX_NODES);
  localparam int NCW = $clog2(MAX_NODES + 1);
  localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int SW  = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int SCW = $clog2(SOURCES + 1);
  localparam int DW  = SOURCES * MAX_NODES;
  localparam int DAW = $clog2(DW);
  localparam int EdW = 2 * NW + WeightW;
  localparam int RW  = DistW + 1;

  // edge memory
  logic [EdW-1:0] edge_mem [MAX_EDGES];
  logic [EdW-1:0] edge_rd_q;
  logic [ECW-1:0] edge_cnt_q;
  // current row: scratch, one port read by scan, one by relax
  logic [RW-1:0]  row_mem [MAX_NODES];
  logic [RW-1:0]  scan_rd_q, relax_rd_q;
  logic [MAX_NODES-1:0] settled_q;
  // distance table
  logic [RW-1:0]  dist_mem [DW];
  logic [RW-1:0]  dist_rd_q;

  logic [NCW-1:0] n_q;
  logic [SCW-1:0] src_cnt_q;
  logic [SCW-1:0] computed_q;
  logic [SW-1:0]  src_q;
  logic [NW:0]    idx_q;
  logic [NW-1:0]  idx_r_q;
  logic           idx_rv_q;
  logic [NW-1:0]  best_q;
  logic [DistW-1:0] bestd_q;
  logic           found_q;
  logic [ECW-1:0] eidx_q;
  logic           e_rv_q;
  logic [1:0]     b_pipe_q;
  logic [EdW-1:0] e_q;
  logic           e_v_q;

  logic [NCW-1:0] n_eff;
  always_comb begin
    if (node_count_i == '0) n_eff = NCW'(1);
    else if (32'(node_count_i) > MAX_NODES) n_eff = NCW'(MAX_NODES);
    else n_eff = NCW'(node_count_i);
  end

  // query pipeline: registered memory read
  logic           q_pend_q;
  logic           q_nosrc_q, q_oor_q;
  logic           res_valid_q;
  logic [DistW-1:0] res_dist_q;
  logic [StatusW-1:0] res_st_q;
  logic [NCW-1:0] n_last_q;

  logic [DAW-1:0] q_addr;
  assign q_addr = DAW'(32'(node_a_i) * MAX_NODES + 32'(node_b_i));

  logic [DAW-1:0] row_base;
  assign row_base = DAW'(32'(src_q) * MAX_NODES);

  // relax candidate, edge end node
  logic [NW-1:0]  e_from, e_to;
  logic [WeightW-1:0] e_w;
  assign e_w    = e_q[WeightW-1:0];
  assign e_to   = e_q[WeightW +: NW];
  assign e_from = e_q[WeightW+NW +: NW];

  logic [DistW:0] cand_sum;
  logic [DistW-1:0] cand;
  assign cand_sum = {1'b0, bestd_q} + (DistW+1)'(e_w);
  assign cand = cand_sum[DistW] ? DistMax : cand_sum[DistW-1:0];

  // relax: read end node first, then write; edges are handled one at a time
  logic relax_hit;
  assign relax_hit = e_v_q && (e_from == best_q) &&
                     (NCW'(e_from) < n_q) && (NCW'(e_to) < n_q);

  logic relax_wr;
  assign relax_wr = b_pipe_q[1] && relax_hit &&
                    (!relax_rd_q[DistW] || cand < relax_rd_q[DistW-1:0]);

  logic init_last, scan_last;
  assign init_last = (idx_q == (NW+1)'(MAX_NODES - 1));
  assign scan_last = idx_rv_q && (NCW'(idx_r_q) == n_q - NCW'(1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_edge && 32'(edge_cnt_q) < MAX_EDGES)
      edge_mem[edge_cnt_q[EW-1:0]] <= {node_a_i[NW-1:0], node_b_i[NW-1:0], weight_i};
    edge_rd_q <= edge_mem[eidx_q[EW-1:0]];

    if (cmd_i.init_row)
      row_mem[idx_q[NW-1:0]] <= (idx_q[NW-1:0] == NW'(src_q)) ? {1'b1, {DistW{1'b0}}} : '0;
    else if (relax_wr)
      row_mem[e_to] <= {1'b1, cand};
    scan_rd_q  <= row_mem[idx_q[NW-1:0]];
    relax_rd_q <= row_mem[e_to];

    if (cmd_i.init_row)
      dist_mem[row_base + DAW'(idx_q[NW-1:0])] <=
        (idx_q[NW-1:0] == NW'(src_q)) ? {1'b1, {DistW{1'b0}}} : '0;
    else if (relax_wr)
      dist_mem[row_base + DAW'(e_to)] <= {1'b1, cand};
    dist_rd_q <= dist_mem[q_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_cnt_q  <= '0;
      computed_q  <= '0;
      n_q <= NCW'(1); n_last_q <= NCW'(1);
      src_cnt_q <= '0; src_q <= '0;
      idx_q <= '0; idx_r_q <= '0; idx_rv_q <= 1'b0;
      settled_q <= '0;
      best_q <= '0; bestd_q <= '0; found_q <= 1'b0;
      eidx_q <= '0; e_rv_q <= 1'b0; b_pipe_q <= '0; e_q <= '0; e_v_q <= 1'b0;
      q_pend_q <= 1'b0; q_nosrc_q <= 1'b0; q_oor_q <= 1'b0;
      res_valid_q <= 1'b0; res_dist_q <= '0; res_st_q <= StFound;
    end else begin
      if (cmd_i.add_edge && 32'(edge_cnt_q) < MAX_EDGES) edge_cnt_q <= edge_cnt_q + 1'b1;
      if (cmd_i.clear_edges) edge_cnt_q <= '0;

      if (cmd_i.start_compute) begin
        n_q <= n_eff;
        src_cnt_q <= (32'(n_eff) < SOURCES) ? SCW'(n_eff) : SCW'(SOURCES);
        src_q <= '0;
        idx_q <= '0;
        computed_q <= '0;
      end
      if (cmd_i.init_row) begin
        idx_q <= init_last ? '0 : idx_q + 1'b1;
        settled_q <= '0;
        found_q <= 1'b0;
        idx_rv_q <= 1'b0;
      end
      if (cmd_i.scan_step) begin
        // read at idx_q, compare in the next cycle
        if (NCW'(idx_q) < n_q) idx_q <= idx_q + 1'b1;
        idx_r_q  <= idx_q[NW-1:0];
        idx_rv_q <= (NCW'(idx_q) < n_q);
        if (idx_rv_q && !settled_q[idx_r_q] && scan_rd_q[DistW] &&
            (!found_q || scan_rd_q[DistW-1:0] < bestd_q)) begin
          found_q <= 1'b1;
          best_q  <= idx_r_q;
          bestd_q <= scan_rd_q[DistW-1:0];
        end
      end
      if (cmd_i.pick_min) begin
        idx_q <= '0; idx_rv_q <= 1'b0;
        // every round searches afresh
        found_q <= 1'b0;
        if (found_q) settled_q[best_q] <= 1'b1;
        eidx_q <= '0; e_rv_q <= 1'b0; b_pipe_q <= '0; e_v_q <= 1'b0;
      end
      if (cmd_i.relax_step) begin
        // two phase per edge: fetch edge, then read end node and write
        b_pipe_q <= {b_pipe_q[0], 1'b0};
        if (b_pipe_q == 2'b00 && !e_rv_q) begin
          e_rv_q <= 1'b1;
        end else if (e_rv_q) begin
          e_rv_q <= 1'b0;
          e_q <= edge_rd_q;
          e_v_q <= (eidx_q < edge_cnt_q);
          b_pipe_q <= 2'b01;
        end
        if (b_pipe_q[1]) begin
          eidx_q <= eidx_q + 1'b1;
          e_v_q <= 1'b0;
        end
      end
      if (cmd_i.next_source) begin
        found_q <= 1'b0;
        idx_q <= '0;
        src_q <= src_q + 1'b1;
        computed_q <= (SCW'(src_q) + 1'b1 == src_cnt_q) ? src_cnt_q : computed_q;
        n_last_q <= n_q;
      end

      if (res_valid_q && res_ready_i) res_valid_q <= 1'b0;
      q_pend_q <= cmd_i.query;
      if (cmd_i.query) begin
        q_nosrc_q <= (SCW'(node_a_i) >= computed_q) || (32'(node_a_i) >= SOURCES);
        q_oor_q   <= (NCW'(node_b_i) >= n_last_q) || (32'(node_b_i) >= MAX_NODES);
      end
      if (q_pend_q) begin
        res_valid_q <= 1'b1;
        if (q_nosrc_q) begin
          res_dist_q <= '0; res_st_q <= StNoSrc;
        end else if (q_oor_q || !dist_rd_q[DistW]) begin
          res_dist_q <= '0; res_st_q <= StUnreach;
        end else begin
          res_dist_q <= dist_rd_q[DistW-1:0]; res_st_q <= StFound;
        end
      end
    end
  end

  assign sts_o.init_done    = init_last;
  assign sts_o.scan_done    = scan_last || (idx_rv_q && 1'b0) ||
                              (cmd_i.scan_step && !idx_rv_q && NCW'(idx_q) >= n_q);
  assign sts_o.none_found   = !found_q;
  assign sts_o.relax_done   = e_rv_q && !(eidx_q < edge_cnt_q);
  assign sts_o.sources_done = (SCW'(src_q) + 1'b1 == src_cnt_q);
  // a query result is on its way or waiting
  assign sts_o.res_busy     = res_valid_q || q_pend_q;

  assign res_valid_o    = res_valid_q;
  assign res_distance_o = res_dist_q;
  assign res_status_o   = res_st_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.query |=> q_pend_q)
    else $error("query not pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pend_q |=> res_valid_q)
    else $error("query result lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(edge_cnt_q) <= MAX_EDGES)
    else $error("edge count overflow");

endmodule

// ----- design/multi_source_shortest_path.sv -----
// Multi-source shortest path engine. Edge loads (opcode 0) and clears (opcode 3)
// update the edge list; a query (opcode 2) reads the distance memory into a
// registered result, and the input waits until that result is taken. A compute
// (opcode 1) runs Dijkstra with a linear minimum scan from each of the first
// min(n, SOURCES) nodes, n being node_count clamped to 1..MAX_NODES; per source
// it clears a row, then every search round scans the row memory and picks the
// nearest unsettled node, each settled node's edges are relaxed in a pass over
// every stored edge, and a last step moves on to the next source. node_count
// takes effect at the next compute.
module multi_source_shortest_path import mssp_pkg::*; #(
  parameter int MAX_NODES = MaxNodesDef,
  parameter int MAX_EDGES = MaxEdgesDef,
  parameter int SOURCES   = SourcesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // opcode[1:0], node_a[7:2], node_b[13:8], weight[29:14], zero pad
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // distance[21:0], status[23:22]
  output logic [23:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i
);

  mssp_cmd_t cmd;
  mssp_sts_t sts;
  logic [CountW-1:0] node_count_q;
  logic [DistW-1:0] res_dist;
  logic [StatusW-1:0] status;

  // node count register, written any time
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= CountW'(64);
    end else if (cfg_valid_i) begin
      node_count_q <= cfg_data_i;
    end
  end

  mssp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_opcode_i(s_axis_tdata[1:0]),
    .in_ready_o (s_axis_tready),
    .res_busy_i (sts.res_busy),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mssp_dp #(
    .MAX_NODES(MAX_NODES),
    .MAX_EDGES(MAX_EDGES),
    .SOURCES  (SOURCES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .node_count_i  (node_count_q),
    .node_a_i      (s_axis_tdata[7:2]),
    .node_b_i      (s_axis_tdata[13:8]),
    .weight_i      (s_axis_tdata[29:14]),
    .res_valid_o   (m_axis_tvalid),
    .res_ready_i   (m_axis_tready),
    .res_distance_o(res_dist),
    .res_status_o  (status)
  );

  assign m_axis_tdata = {status, res_dist};

endmodule

// ----- verif/tb.sv -----
module tb;
  import mssp_pkg::*;

  localparam int NodeSlots = 64;
  localparam int EdgeSlots = 1024;
  localparam int SrcRows   = 10;

  typedef struct packed {
    logic [DistW-1:0]   distance;
    logic [StatusW-1:0] status;
  } answer_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [6:0]  cfg_data_i;

  multi_source_shortest_path dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  // shadow copy of the graph and distance rows
  logic [6:0]         node_reg;
  logic [NodeW-1:0]   edge_src [EdgeSlots];
  logic [NodeW-1:0]   edge_dst [EdgeSlots];
  logic [WeightW-1:0] edge_wt  [EdgeSlots];
  int unsigned        edge_total;
  logic [DistW:0]     dist_rows [SrcRows][NodeSlots];
  int unsigned        rows_ready;

  answer_t     answer_q[$];
  int unsigned fail_count;
  int unsigned burst_left;
  int unsigned random_items;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #200000000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  // dijkstra from every computed source, linear min scan, saturating lengths
  function automatic void compute_distances();
    int unsigned n, cnt, s, v, e, r, best;
    logic [DistW-1:0] bestd;
    logic [DistW+1:0] cand;
    bit settled [NodeSlots];
    n = (node_reg == 0) ? 1 : (node_reg > NodeSlots) ? NodeSlots : node_reg;
    cnt = (n < SrcRows) ? n : SrcRows;
    for (s = 0; s < cnt; s++) begin
      for (v = 0; v < NodeSlots; v++) begin
        dist_rows[s][v] = '0;
        settled[v] = 1'b0;
      end
      dist_rows[s][s] = {1'b1, {DistW{1'b0}}};
      for (r = 0; r < n; r++) begin
        best = n;
        bestd = '0;
        for (v = 0; v < n; v++) begin
          if (settled[v] || !dist_rows[s][v][DistW]) continue;
          if (best == n || dist_rows[s][v][DistW-1:0] < bestd) begin
            best = v;
            bestd = dist_rows[s][v][DistW-1:0];
          end
        end
        if (best == n) break;
        settled[best] = 1'b1;
        for (e = 0; e < edge_total; e++) begin
          if (edge_src[e] != best || edge_src[e] >= n || edge_dst[e] >= n) continue;
          cand = bestd + edge_wt[e];
          if (cand > DistMax) cand = DistMax;
          if (!dist_rows[s][edge_dst[e]][DistW] ||
              cand[DistW-1:0] < dist_rows[s][edge_dst[e]][DistW-1:0])
            dist_rows[s][edge_dst[e]] = {1'b1, cand[DistW-1:0]};
        end
      end
    end
    rows_ready = cnt;
  endfunction

  function automatic void predict(input logic [1:0] op, input logic [NodeW-1:0] a,
                                  input logic [NodeW-1:0] b, input logic [WeightW-1:0] w);
    answer_t ans;
    case (op)
      OpAdd: begin
        if (edge_total < EdgeSlots) begin
          edge_src[edge_total] = a;
          edge_dst[edge_total] = b;
          edge_wt[edge_total] = w;
          edge_total++;
        end
      end
      OpCompute: compute_distances();
      OpClear: edge_total = 0;
      default: begin
        if (a >= rows_ready) begin
          ans = '{distance: '0, status: StNoSrc};
        end else if (!dist_rows[a][b][DistW]) begin
          ans = '{distance: '0, status: StUnreach};
        end else begin
          ans = '{distance: dist_rows[a][b][DistW-1:0], status: StFound};
        end
        answer_q.push_back(ans);
      end
    endcase
  endfunction

  // one transfer on the input stream, with bursts and random gaps
  task automatic send_item(input logic [1:0] op, input logic [NodeW-1:0] a,
                           input logic [NodeW-1:0] b, input logic [WeightW-1:0] w);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 40);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, w, b, a, op};
    do @(posedge clk_i); while (!s_axis_tready);
    predict(op, a, b, w);
  endtask

  task automatic idle_input();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  // every answer in and a few spare cycles, so the block is quiet
  task automatic drain();
    idle_input();
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  // a query waits behind a running compute, so its answer marks the end of it
  task automatic settle();
    send_item(OpQuery, 6'd0, 6'd0, 16'd0);
    drain();
  endtask

  task automatic write_nodes(input logic [6:0] val);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    node_reg = val;
  endtask

  task automatic test_directed();
    send_item(OpQuery, 6'd0, 6'd0, 16'd0);    // no compute yet
    send_item(OpAdd, 6'd0, 6'd1, 16'hFFFF);
    send_item(OpAdd, 6'd1, 6'd2, 16'hFFFF);
    send_item(OpAdd, 6'd0, 6'd2, 16'd0);
    send_item(OpAdd, 6'd2, 6'd63, 16'd7);
    send_item(OpAdd, 6'd63, 6'd9, 16'd1);
    send_item(OpCompute, 6'd0, 6'd0, 16'd0);
    send_item(OpQuery, 6'd0, 6'd1, 16'd0);
    send_item(OpQuery, 6'd0, 6'd9, 16'd0);
    send_item(OpQuery, 6'd1, 6'd0, 16'd0);    // unreachable
    send_item(OpQuery, 6'd9, 6'd9, 16'd0);
    send_item(OpQuery, 6'd10, 6'd1, 16'd0);   // beyond the computed rows
    send_item(OpQuery, 6'd63, 6'd63, 16'd0);
    send_item(OpClear, 6'd0, 6'd0, 16'd0);
    send_item(OpQuery, 6'd0, 6'd63, 16'd0);   // still readable after clear
    settle();
    write_nodes(7'd3);
    send_item(OpAdd, 6'd1, 6'd4, 16'd3);      // end outside node range
    send_item(OpAdd, 6'd1, 6'd2, 16'd5);
    send_item(OpCompute, 6'd0, 6'd0, 16'd0);
    send_item(OpQuery, 6'd1, 6'd4, 16'd0);
    send_item(OpQuery, 6'd1, 6'd2, 16'd0);
    send_item(OpQuery, 6'd3, 6'd0, 16'd0);
    settle();
  endtask

  // out-of-range register values fold to 1 and to the full node count
  task automatic test_node_limits();
    logic [6:0] vals [4] = '{7'd0, 7'd127, 7'd1, 7'd64};
    int i;
    for (i = 0; i < 4; i++) begin
      write_nodes(vals[i]);
      send_item(OpClear, 6'd0, 6'd0, 16'd0);
      send_item(OpAdd, 6'd0, 6'd1, 16'd11);
      send_item(OpAdd, 6'd1, 6'd0, 16'd4);
      send_item(OpCompute, 6'd0, 6'd0, 16'd0);
      send_item(OpQuery, 6'd0, 6'd1, 16'd0);
      send_item(OpQuery, 6'd1, 6'd0, 16'd0);
      send_item(OpQuery, 6'd9, 6'd0, 16'd0);
      settle();
    end
  endtask

  // fill the edge list past its end; the extra adds are dropped
  task automatic test_edge_full();
    int i;
    write_nodes(7'd2);
    send_item(OpClear, 6'd0, 6'd0, 16'd0);
    for (i = 0; i < EdgeSlots + 6; i++)
      send_item(OpAdd, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                16'($urandom));
    send_item(OpCompute, 6'd0, 6'd0, 16'd0);
    for (i = 0; i < 4; i++)
      send_item(OpQuery, 6'(i / 2), 6'(i % 2), 16'd0);
    settle();
  endtask

  task automatic rand_item(input int unsigned n);
    logic [NodeW-1:0] a, b;
    int unsigned pick;
    a = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, n - 1));
    b = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, n - 1));
    pick = $urandom_range(0, 19);
    if (pick < 12) send_item(OpQuery, a, b, 16'd0);
    else if (pick < 19) send_item(OpAdd, a, b, 16'($urandom));
    else send_item(OpClear, a, b, 16'($urandom));
    random_items++;
  endtask

  // graphs with random shapes: load, compute, query, with noise mixed in
  task automatic test_random_graphs();
    int unsigned n, i, k;
    bit wide_done;
    wide_done = 1'b0;
    while (random_items < 340) begin
      if (!wide_done && random_items > 150) begin
        n = 64;
        wide_done = 1'b1;
      end else begin
        n = $urandom_range(2, 12);
      end
      write_nodes(7'(n));
      send_item(OpClear, 6'd0, 6'd0, 16'd0);
      k = $urandom_range(3, (n == 64) ? 20 : 3 * n);
      for (i = 0; i < k; i++) begin
        send_item(OpAdd,
                  ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, n - 1)),
                  ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, n - 1)),
                  ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 8)) : 16'($urandom));
        random_items++;
      end
      send_item(OpCompute, 6'd0, 6'd0, 16'd0);
      random_items++;
      k = $urandom_range(10, 30);
      for (i = 0; i < k; i++) rand_item(n);
      if ($urandom_range(0, 2) == 0) begin
        send_item(OpCompute, 6'd0, 6'd0, 16'd0);
        for (i = 0; i < 8; i++) rand_item(n);
      end
      settle();
    end
  endtask

  // receiver stall pattern: rotates through four modes
  int unsigned stall_cycle = 0;
  always @(posedge clk_i) begin
    stall_cycle <= stall_cycle + 1;
    case ((stall_cycle / 150) % 4)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= $urandom_range(0, 1);
      2: m_axis_tready <= (stall_cycle % 4 == 0);
      default: m_axis_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // check each result transfer against the oldest expected answer
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (answer_q.size() == 0) begin
        report($sformatf("unexpected result %h", m_axis_tdata));
      end else begin
        want = answer_q.pop_front();
        if (m_axis_tdata[21:0] != want.distance)
          report($sformatf("distance %0d, want %0d", m_axis_tdata[21:0], want.distance));
        if (m_axis_tdata[23:22] != want.status)
          report($sformatf("status %0d, want %0d", m_axis_tdata[23:22], want.status));
      end
    end
  end

  initial begin
    int unsigned waited;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    node_reg = 7'd64;
    edge_total = 0;
    rows_ready = 0;
    fail_count = 0;
    burst_left = 0;
    random_items = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_node_limits();
    test_edge_full();
    test_random_graphs();
    idle_input();
    waited = 0;
    while (answer_q.size() != 0 && waited < 100000) begin
      @(posedge clk_i);
      waited++;
    end
    if (answer_q.size() != 0) report("answers still outstanding at end");
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
